// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is active.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/fhrf_pkg.sv =====
package fhrf_pkg;

    // Widths fixed by the register map and the stream fields
    localparam int CFG_W      = 11;
    localparam int NEAR_W     = 10;
    localparam int PIX_W      = 8;
    localparam int HEADING_W  = 10;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    // Common width for size and count compares (covers sizes up to 8191)
    localparam int SIZE_W     = 13;

    // Register reset values
    localparam logic [CFG_W-1:0]  FRAME_WIDTH_RESET  = 11'd520;
    localparam logic [CFG_W-1:0]  FRAME_HEIGHT_RESET = 11'd240;
    localparam logic [CFG_W-1:0]  PLANT_LIMIT_RESET  = 11'd30;
    localparam logic [NEAR_W-1:0] NEAR_ROWS_RESET    = 10'd35;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_PLANT_LIMIT  = 2'd2,
        REG_NEAR_ROWS    = 2'd3
    } reg_addr_t;

    // Open box in YUV space: every bound exclusive
    typedef struct packed {
        logic [PIX_W-1:0] y_lo;
        logic [PIX_W-1:0] y_hi;
        logic [PIX_W-1:0] c1_lo;
        logic [PIX_W-1:0] c1_hi;
        logic [PIX_W-1:0] c2_lo;
        logic [PIX_W-1:0] c2_hi;
    } color_box_t;

    localparam color_box_t DARK_GRAY_BOX = '{8'd10, 8'd110, 8'd110, 8'd135, 8'd125, 8'd150};
    localparam color_box_t BLUE_BOX      = '{8'd60, 8'd100, 8'd145, 8'd165, 8'd85, 8'd105};
    localparam color_box_t GREEN_BOX     = '{8'd50, 8'd150, 8'd80, 8'd180, 8'd0, 8'd125};

    typedef struct packed {
        logic floor_hit;
        logic green_hit;
    } pixel_class_t;

    function automatic logic in_box(
        input color_box_t       box,
        input logic [PIX_W-1:0] y,
        input logic [PIX_W-1:0] c1,
        input logic [PIX_W-1:0] c2
    );
        in_box = (y > box.y_lo) && (y < box.y_hi)
              && (c1 > box.c1_lo) && (c1 < box.c1_hi)
              && (c2 > box.c2_lo) && (c2 < box.c2_hi);
    endfunction

endpackage

// ===== src/fhrf_classify.sv =====
module fhrf_classify
(
    input  logic [fhrf_pkg::PIX_W-1:0] luma,
    input  logic [fhrf_pkg::PIX_W-1:0] chroma_first,
    input  logic [fhrf_pkg::PIX_W-1:0] chroma_second,
    output fhrf_pkg::pixel_class_t     pixel_class
);

    always_comb
    begin
        pixel_class.floor_hit =
            fhrf_pkg::in_box(fhrf_pkg::DARK_GRAY_BOX, luma, chroma_first, chroma_second)
            || fhrf_pkg::in_box(fhrf_pkg::BLUE_BOX, luma, chroma_first, chroma_second);
        pixel_class.green_hit =
            fhrf_pkg::in_box(fhrf_pkg::GREEN_BOX, luma, chroma_first, chroma_second);
    end

endmodule

// ===== src/free_heading_row_finder.sv =====
// Free heading row finder. Feed one unpacked YUV pixel per request in row-major
// order (s_tdata: luma, chroma_first, chroma_second; s_tuser: frame_start, which
// clears all counters before that pixel counts). The block tracks column and row
// against frame_width and frame_height, clamped to 2..MAX_WIDTH and 1..MAX_HEIGHT
// and read live, so shrinking the frame mid-way ends the row or frame at once.
// Left-half pixels inside the dark-gray or blue box mark the row free; right-half
// pixels inside the green box count toward plant_pixel_limit. After the last pixel
// of a frame one request goes out on m_tdata: the middle row of the longest free
// run, or frame_height/2 when no run was recorded; counters then clear on their own.
// Throughput is one pixel per clock unless the input side stalls. The accepted
// pixel sits in the input register while the box compares and counter update
// run, and the result register presents the heading. The input side stalls only
// when a frame-end pixel finds the result register still full and not being
// taken. Registers sit on APB at byte addresses 0x0 frame_width, 0x4 frame_height,
// 0x8 plant_pixel_limit, 0xC near_obstacle_rows; write them only while the block
// is idle.
module free_heading_row_finder
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // APB register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fhrf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fhrf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fhrf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // Pixel stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fhrf_pkg::S_TDATA_W-1:0]    s_tdata,  // [7:0] luma, [15:8] chroma_first,
                                                        // [23:16] chroma_second
    input  logic                              s_tuser,  // [0] frame_start
    // Heading result out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fhrf_pkg::M_TDATA_W-1:0]    m_tdata   // [9:0] heading_row, [15:10] zero
);

    localparam int SW = fhrf_pkg::SIZE_W;
    localparam int PW = fhrf_pkg::PIX_W;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int GW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int RESET_HEIGHT =
        (int'(fhrf_pkg::FRAME_HEIGHT_RESET) > MAX_HEIGHT) ? MAX_HEIGHT
                                                          : int'(fhrf_pkg::FRAME_HEIGHT_RESET);
    localparam logic [HW-1:0] BEST_ROW_RESET = HW'(RESET_HEIGHT / 2);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [fhrf_pkg::CFG_W-1:0]  frame_width_reg;
    logic [fhrf_pkg::CFG_W-1:0]  frame_height_reg;
    logic [fhrf_pkg::CFG_W-1:0]  plant_limit_reg;
    logic [fhrf_pkg::NEAR_W-1:0] near_rows_reg;
    logic                        cfg_write;
    fhrf_pkg::reg_addr_t         cfg_addr;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_addr  = fhrf_pkg::reg_addr_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= fhrf_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= fhrf_pkg::FRAME_HEIGHT_RESET;
            plant_limit_reg  <= fhrf_pkg::PLANT_LIMIT_RESET;
            near_rows_reg    <= fhrf_pkg::NEAR_ROWS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                fhrf_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[fhrf_pkg::CFG_W-1:0];
                fhrf_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[fhrf_pkg::CFG_W-1:0];
                fhrf_pkg::REG_PLANT_LIMIT:  plant_limit_reg  <= pwdata[fhrf_pkg::CFG_W-1:0];
                fhrf_pkg::REG_NEAR_ROWS:    near_rows_reg    <= pwdata[fhrf_pkg::NEAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_addr)
            fhrf_pkg::REG_FRAME_WIDTH:  prdata = fhrf_pkg::APB_DATA_W'(frame_width_reg);
            fhrf_pkg::REG_FRAME_HEIGHT: prdata = fhrf_pkg::APB_DATA_W'(frame_height_reg);
            fhrf_pkg::REG_PLANT_LIMIT:  prdata = fhrf_pkg::APB_DATA_W'(plant_limit_reg);
            fhrf_pkg::REG_NEAR_ROWS:    prdata = fhrf_pkg::APB_DATA_W'(near_rows_reg);
            default:                    prdata = '0;
        endcase
    end

    // Clamp frame size to what the counters can address
    logic [SW-1:0] eff_width;
    logic [SW-1:0] eff_height;
    logic [SW-1:0] half_width;
    logic [SW-1:0] half_height;

    always_comb
    begin
        eff_width = SW'(frame_width_reg);
        if (eff_width < SW'(2))
            eff_width = SW'(2);
        if (eff_width > SW'(MAX_WIDTH))
            eff_width = SW'(MAX_WIDTH);
        eff_height = SW'(frame_height_reg);
        if (eff_height < SW'(1))
            eff_height = SW'(1);
        if (eff_height > SW'(MAX_HEIGHT))
            eff_height = SW'(MAX_HEIGHT);
        half_width  = eff_width >> 1;
        half_height = eff_height >> 1;
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic          in_valid_reg;
    logic [PW-1:0] luma_reg;
    logic [PW-1:0] chroma_first_reg;
    logic [PW-1:0] chroma_second_reg;
    logic          frame_start_reg;
    logic          in_accept;
    logic          advance;
    logic          emit;

    assign in_accept = s_tvalid && s_tready;
    // Hold the pixel only when it would overwrite an unread result
    assign advance   = !emit || !m_tvalid || m_tready;
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            luma_reg          <= s_tdata[PW-1:0];
            chroma_first_reg  <= s_tdata[2*PW-1:PW];
            chroma_second_reg <= s_tdata[3*PW-1:2*PW];
            frame_start_reg   <= s_tuser;
        end
    end

    fhrf_pkg::pixel_class_t pixel_class;

    fhrf_classify u_classify
    (
        .luma          (luma_reg),
        .chroma_first  (chroma_first_reg),
        .chroma_second (chroma_second_reg),
        .pixel_class   (pixel_class)
    );

    // ------------------------------------------------------------------
    // Row and frame state
    // ------------------------------------------------------------------
    logic [CW-1:0] column_reg,     column_next;
    logic [HW-1:0] row_reg,        row_next;
    logic          row_free_reg,   row_free_next;
    logic [GW-1:0] green_reg,      green_next;
    logic [RW-1:0] free_run_reg,   free_run_next;
    logic [RW-1:0] best_run_reg,   best_run_next;
    logic [RW-1:0] obst_run_reg,   obst_run_next;
    logic [HW-1:0] best_row_reg,   best_row_next;
    logic [fhrf_pkg::HEADING_W-1:0] heading_next;
    logic [fhrf_pkg::HEADING_W-1:0] heading_reg;
    logic          out_valid_reg,  out_valid_next;

    // Working copies after an optional frame-start clear
    logic [CW-1:0] cur_column;
    logic [HW-1:0] cur_row;
    logic          cur_free;
    logic [GW-1:0] cur_green;
    logic [RW-1:0] cur_free_run;
    logic [RW-1:0] cur_best_run;
    logic [RW-1:0] cur_obst_run;
    logic [HW-1:0] cur_best_row;
    logic          first_half;
    logic          row_end;
    logic          frame_end;
    logic          plant;
    logic [SW-1:0] run_wide;
    logic [SW-1:0] best_row_wide;
    logic [SW-1:0] answer;

    always_comb
    begin
        if (frame_start_reg)
        begin
            cur_column   = '0;
            cur_row      = '0;
            cur_free     = 1'b0;
            cur_green    = '0;
            cur_free_run = '0;
            cur_best_run = '0;
            cur_obst_run = '0;
            cur_best_row = HW'(half_height);
        end
        else
        begin
            cur_column   = column_reg;
            cur_row      = row_reg;
            cur_free     = row_free_reg;
            cur_green    = green_reg;
            cur_free_run = free_run_reg;
            cur_best_run = best_run_reg;
            cur_obst_run = obst_run_reg;
            cur_best_row = best_row_reg;
        end

        // Classify this pixel into the row's tallies
        first_half    = SW'(cur_column) < half_width;
        row_free_next = cur_free || (first_half && pixel_class.floor_hit);
        green_next    = cur_green + GW'(!first_half && pixel_class.green_hit);

        column_next   = cur_column + CW'(1);
        row_next      = cur_row;
        free_run_next = cur_free_run;
        best_run_next = cur_best_run;
        obst_run_next = cur_obst_run;
        best_row_next = cur_best_row;
        heading_next  = '0;
        plant         = 1'b0;
        run_wide      = '0;
        best_row_wide = '0;
        answer        = '0;

        row_end   = (SW'(cur_column) + SW'(1)) >= eff_width;
        frame_end = row_end && ((SW'(cur_row) + SW'(1)) >= eff_height);

        if (row_end)
        begin
            plant         = SW'(green_next) >= SW'(plant_limit_reg);
            free_run_next = cur_free_run + RW'(row_free_next);
            if (!row_free_next || plant)
            begin
                // Record the free run if it is the longest so far; a plant row clears it
                if (free_run_next > cur_best_run)
                begin
                    best_run_next = free_run_next;
                    run_wide      = (SW'(free_run_next) - SW'(cur_row[0])) >> 1;
                    best_row_wide = SW'(cur_row) - run_wide;
                    best_row_next = HW'(best_row_wide);
                end
                if (plant)
                    free_run_next = '0;
                else
                    obst_run_next = cur_obst_run + RW'(1);
            end
            else
            begin
                // A long obstacle restarts the run, a short one is bridged
                if (SW'(cur_obst_run) > SW'(near_rows_reg))
                    free_run_next = RW'(1);
                else
                    free_run_next = free_run_next + cur_obst_run;
                obst_run_next = '0;
            end
            row_free_next = 1'b0;
            green_next    = '0;
            column_next   = '0;
            row_next      = cur_row + HW'(1);

            if (frame_end)
            begin
                answer       = (best_run_next == '0) ? half_height : SW'(best_row_next);
                heading_next = fhrf_pkg::HEADING_W'(answer);
                // Drop back to a fresh frame
                row_next      = '0;
                free_run_next = '0;
                best_run_next = '0;
                obst_run_next = '0;
                best_row_next = HW'(half_height);
            end
        end
    end

    assign emit = in_valid_reg && frame_end;

    always_comb
    begin
        if (in_valid_reg && advance && frame_end)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            column_reg    <= '0;
            row_reg       <= '0;
            row_free_reg  <= 1'b0;
            green_reg     <= '0;
            free_run_reg  <= '0;
            best_run_reg  <= '0;
            obst_run_reg  <= '0;
            best_row_reg  <= BEST_ROW_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (in_valid_reg && advance)
            begin
                column_reg   <= column_next;
                row_reg      <= row_next;
                row_free_reg <= row_free_next;
                green_reg    <= green_next;
                free_run_reg <= free_run_next;
                best_run_reg <= best_run_next;
                obst_run_reg <= obst_run_next;
                best_row_reg <= best_row_next;
            end
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance && frame_end)
            heading_reg <= heading_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = fhrf_pkg::M_TDATA_W'(heading_reg);

endmodule

// ===== src/fhrf_checker.sv =====
`include "assert_macros.svh"

module fhrf_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fhrf_pkg::M_TDATA_W-1:0] m_tdata
);

    // A pending result stays up until taken, with its data unchanged
    `ASSERT_NEXT(a_result_held, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_result_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    // Input stalls only while an unread result blocks the output register
    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, !s_tready, m_tvalid && !m_tready)
    // Padding above the heading row is always zero
    `ASSERT_IMPLY(a_pad_zero, clk, rst_n, m_tvalid,
        m_tdata[fhrf_pkg::M_TDATA_W-1:fhrf_pkg::HEADING_W] == '0)

endmodule

bind free_heading_row_finder fhrf_checker u_fhrf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
